/* src/svt_pkg.sv */
package svt_pkg;

  // Default sizes of the stores and the voxel width
  localparam int unsigned SvtMaxColsDef   = 256;
  localparam int unsigned SvtMaxRowsDef   = 256;
  localparam int unsigned SvtMaxSlicesDef = 256;
  localparam int unsigned SvtVoxelBitsDef = 8;

  // Configuration port and result widths
  localparam int unsigned CfgW     = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned TotalW   = 32;
  localparam logic [CfgW-1:0] CfgResetCount = 9'd256;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_SLICES  = 2'd2
  } svt_cfg_idx_e;

  // Control flags of one voxel as it moves down the pipeline
  typedef struct packed {
    logic valid;
    logic first_row;
    logic first_slice;
    logic vol_end;
  } svt_issue_t;

  // Map a register value to a usable count: zero means one, clamp at the store size
  function automatic logic [CfgW-1:0] clamp_count(logic [CfgW-1:0] value,
                                                   int unsigned maximum);
    logic [CfgW-1:0] res;
    res = (value == '0) ? CfgW'(1) : value;
    if (32'(res) > maximum) begin
      res = maximum[CfgW-1:0];
    end
    return res;
  endfunction

endpackage

/* src/svt_intf.sv */
interface svt_voxel_if #(
  parameter int unsigned VOXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [VOXEL_BITS-1:0] voxel;

  modport source (output valid, output voxel, input ready);
  modport sink   (input valid, input voxel, output ready);
endinterface

interface svt_result_if;
  import svt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TotalW-1:0] total;
  logic              volume_end;

  modport source (output valid, output total, output volume_end, input ready);
  modport sink   (input valid, input total, input volume_end, output ready);
endinterface

interface svt_cfg_if;
  import svt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/svt_ram.sv */
module svt_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/svt_ctrl.sv */
module svt_ctrl #(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned MAX_ROWS   = 256,
  parameter int unsigned MAX_SLICES = 256,
  parameter int unsigned VOXEL_BITS = 8,
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned SL_W   = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1,
  localparam int unsigned SLOT_W = (MAX_COLS * MAX_ROWS > 1) ?
                                   $clog2(MAX_COLS * MAX_ROWS) : 1,
  localparam int unsigned RS_W   = (VOXEL_BITS + COL_W > 32) ? 32 : VOXEL_BITS + COL_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [svt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [svt_pkg::CfgW-1:0]       cfg_data_i,
  output logic                           cfg_ready_o,
  input  logic                           vox_valid_i,
  input  logic [VOXEL_BITS-1:0]          vox_data_i,
  output logic                           vox_ready_o,
  input  logic                           adv_i,
  output svt_pkg::svt_issue_t            issue_o,
  output logic [COL_W-1:0]               col_o,
  output logic [SLOT_W-1:0]              slot_o,
  output logic [RS_W-1:0]                row_sum_o
);
  import svt_pkg::*;

  logic [CfgW-1:0]   cols_q, rows_q, slices_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [SL_W-1:0]   slice_q;
  logic [RS_W-1:0]   rs_q, rs_d;
  logic              last_col, last_row, last_slice;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign vox_ready_o = adv_i;
  assign accept      = vox_valid_i && adv_i;

  // Wrap tests on the current position
  assign last_col   = (32'(col_q) + 32'd1)   >= 32'(cols_q);
  assign last_row   = (32'(row_q) + 32'd1)   >= 32'(rows_q);
  assign last_slice = (32'(slice_q) + 32'd1) >= 32'(slices_q);

  // Restart the row sum at the first column
  assign rs_d = (col_q == '0) ? RS_W'(vox_data_i) : rs_q + RS_W'(vox_data_i);

  // Issue the beat to the datapath
  assign issue_o.valid       = accept;
  assign issue_o.first_row   = (row_q == '0);
  assign issue_o.first_slice = (slice_q == '0);
  assign issue_o.vol_end     = last_col && last_row && last_slice;
  assign col_o     = col_q;
  assign slot_o    = SLOT_W'(row_q) * SLOT_W'(MAX_COLS) + SLOT_W'(col_q);
  assign row_sum_o = rs_d;

  // Hold configuration, advance the position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= clamp_count(CfgResetCount, MAX_COLS);
      rows_q   <= clamp_count(CfgResetCount, MAX_ROWS);
      slices_q <= clamp_count(CfgResetCount, MAX_SLICES);
      col_q    <= '0;
      row_q    <= '0;
      slice_q  <= '0;
      rs_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLUMNS: cols_q   <= clamp_count(cfg_data_i, MAX_COLS);
        CFG_ROWS:    rows_q   <= clamp_count(cfg_data_i, MAX_ROWS);
        CFG_SLICES:  slices_q <= clamp_count(cfg_data_i, MAX_SLICES);
        default: ;
      endcase
      if (cfg_index_i == CFG_COLUMNS || cfg_index_i == CFG_ROWS ||
          cfg_index_i == CFG_SLICES) begin
        col_q   <= '0;
        row_q   <= '0;
        slice_q <= '0;
        rs_q    <= '0;
      end
    end else if (accept) begin
      rs_q <= rs_d;
      if (!last_col) begin
        col_q <= col_q + COL_W'(1);
      end else begin
        col_q <= '0;
        if (!last_row) begin
          row_q <= row_q + ROW_W'(1);
        end else begin
          row_q <= '0;
          if (!last_slice) begin
            slice_q <= slice_q + SL_W'(1);
          end else begin
            slice_q <= '0;
          end
        end
      end
    end
  end

endmodule

/* src/svt_datapath.sv */
module svt_datapath #(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned MAX_ROWS   = 256,
  parameter int unsigned VOXEL_BITS = 8,
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned SLOT_W = (MAX_COLS * MAX_ROWS > 1) ?
                                   $clog2(MAX_COLS * MAX_ROWS) : 1,
  localparam int unsigned RS_W   = (VOXEL_BITS + COL_W > 32) ? 32 : VOXEL_BITS + COL_W,
  localparam int unsigned PW     = (VOXEL_BITS + COL_W + ROW_W > 32) ?
                                   32 : VOXEL_BITS + COL_W + ROW_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  output logic                          adv_o,
  input  svt_pkg::svt_issue_t           issue_i,
  input  logic [COL_W-1:0]              col_i,
  input  logic [SLOT_W-1:0]             slot_i,
  input  logic [RS_W-1:0]               row_sum_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic [svt_pkg::TotalW-1:0]    res_total_o,
  output logic                          res_end_o
);
  import svt_pkg::*;

  svt_issue_t        a_q, b_q;
  logic [COL_W-1:0]  a_col_q;
  logic [SLOT_W-1:0] a_slot_q, b_slot_q;
  logic [RS_W-1:0]   a_rs_q;
  logic              a_lfwd_q, a_sfwd_q;
  logic [PW-1:0]     a_ldat_q, b_plane_q;
  logic [TotalW-1:0] a_sdat_q, b_slice_q;
  logic [PW-1:0]     line_rd, line_op, plane_a;
  logic [TotalW-1:0] slice_rd, slice_a, total_b, b_slice_d;
  logic              o_valid_q, o_end_q;
  logic [TotalW-1:0] o_total_q;
  logic              adv;

  // Advance the whole pipeline whenever the output register can take a beat
  assign adv   = !o_valid_q || res_ready_i;
  assign adv_o = adv;

  // Line store: in-slice sums of the previous row
  svt_ram #(.DEPTH(MAX_COLS), .WIDTH(PW)) u_line (
    .clk_i  (clk_i),
    .we_i   (adv && a_q.valid),
    .waddr_i(a_col_q),
    .wdata_i(plane_a),
    .re_i   (adv),
    .raddr_i(col_i),
    .rdata_o(line_rd)
  );

  // Slice store: totals of the previous slice
  svt_ram #(.DEPTH(MAX_COLS * MAX_ROWS), .WIDTH(TotalW)) u_slice (
    .clk_i  (clk_i),
    .we_i   (adv && b_q.valid),
    .waddr_i(b_slot_q),
    .wdata_i(total_b),
    .re_i   (adv),
    .raddr_i(slot_i),
    .rdata_o(slice_rd)
  );

  // Stage A: lift the row sum to the in-slice sum
  assign line_op = a_q.first_row ? '0 : (a_lfwd_q ? a_ldat_q : line_rd);
  assign plane_a = PW'(a_rs_q) + line_op;
  assign slice_a = a_sfwd_q ? a_sdat_q : slice_rd;

  // Take the total from stage B when it writes the slot stage A is about to use
  assign b_slice_d = (b_q.valid && b_slot_q == a_slot_q) ? total_b : slice_a;

  // Stage B: lift the in-slice sum to the volume sum
  assign total_b = TotalW'(b_plane_q) + (b_q.first_slice ? '0 : b_slice_q);

  // Hold control state of the stages and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q       <= '0;
      b_q       <= '0;
      a_lfwd_q  <= 1'b0;
      a_sfwd_q  <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv) begin
      a_q       <= issue_i;
      b_q       <= a_q;
      a_lfwd_q  <= issue_i.valid && a_q.valid && (a_col_q == col_i);
      a_sfwd_q  <= issue_i.valid && b_q.valid && (b_slot_q == slot_i);
      o_valid_q <= b_q.valid;
    end
  end

  // Advance the payload of the stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_col_q   <= col_i;
      a_slot_q  <= slot_i;
      a_rs_q    <= row_sum_i;
      a_ldat_q  <= plane_a;
      a_sdat_q  <= total_b;
      b_slot_q  <= a_slot_q;
      b_plane_q <= plane_a;
      b_slice_q <= b_slice_d;
      o_total_q <= total_b;
      o_end_q   <= b_q.vol_end;
    end
  end

  assign res_valid_o = o_valid_q;
  assign res_total_o = o_total_q;
  assign res_end_o   = o_end_q;

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(a_q) && $stable(b_q))
    else $error("pipeline moved while the output was stalled");

  a_lfwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_lfwd_q |-> a_q.valid)
    else $error("line forward flagged on an empty stage");

  a_sfwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_sfwd_q |-> a_q.valid)
    else $error("slice forward flagged on an empty stage");

  a_out_from_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && b_q.valid |=> o_valid_q)
    else $error("beat from stage B lost on its way to the output");
`endif

endmodule

/* src/summed_volume_table_3d.sv */
// Streaming 3D summed-volume table.
// voxel_i carries voxels in raster order (column fastest, then row, then slice);
// result_o returns one beat per voxel: total is the inclusive prefix sum over
// every voxel at or below it on all three axes, volume_end flags the last voxel.
// cfg_i writes columns, rows and slices (index 0, 1, 2); a write restarts the
// volume at the origin. Writes must come only while the block idles, which the
// block does not enforce. Throughput is one voxel per cycle while result_o does
// not stall. A result reaches result_o through stage A, which adds the line sum,
// stage B, which adds the slice total, and the output register; both stores are
// read at the edge that accepts its voxel. Both are registered-read synchronous
// memories; a result written back in flight is forwarded to the next reader of
// the same entry, so any volume size keeps the full rate. When result_o stalls,
// the whole pipeline holds and voxel_i.ready drops at once. Reset clears the
// pipeline and counters and sets each size to 256, capped at its maximum; the
// stores are not cleared, as the first row and slice never read them.
module summed_volume_table_3d #(
  parameter int unsigned MAX_COLS   = svt_pkg::SvtMaxColsDef,
  parameter int unsigned MAX_ROWS   = svt_pkg::SvtMaxRowsDef,
  parameter int unsigned MAX_SLICES = svt_pkg::SvtMaxSlicesDef,
  parameter int unsigned VOXEL_BITS = svt_pkg::SvtVoxelBitsDef,
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned SLOT_W = (MAX_COLS * MAX_ROWS > 1) ?
                                   $clog2(MAX_COLS * MAX_ROWS) : 1,
  localparam int unsigned RS_W   = (VOXEL_BITS + COL_W > 32) ? 32 : VOXEL_BITS + COL_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  svt_cfg_if.sink             cfg_i,
  svt_voxel_if.sink           voxel_i,
  svt_result_if.source        result_o
);
  import svt_pkg::*;

  svt_issue_t        issue;
  logic [COL_W-1:0]  col;
  logic [SLOT_W-1:0] slot;
  logic [RS_W-1:0]   row_sum;
  logic              adv;

  // Position counters, configuration and the running row sum
  svt_ctrl #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .MAX_SLICES(MAX_SLICES),
    .VOXEL_BITS(VOXEL_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_i.valid),
    .cfg_index_i(cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .cfg_ready_o(cfg_i.ready),
    .vox_valid_i(voxel_i.valid),
    .vox_data_i (VOXEL_BITS'(voxel_i.voxel)),
    .vox_ready_o(voxel_i.ready),
    .adv_i      (adv),
    .issue_o    (issue),
    .col_o      (col),
    .slot_o     (slot),
    .row_sum_o  (row_sum)
  );

  // Store read-modify-write pipeline and output register
  svt_datapath #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .VOXEL_BITS(VOXEL_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_o      (adv),
    .issue_i    (issue),
    .col_i      (col),
    .slot_i     (slot),
    .row_sum_i  (row_sum),
    .res_ready_i(result_o.ready),
    .res_valid_o(result_o.valid),
    .res_total_o(result_o.total),
    .res_end_o  (result_o.volume_end)
  );

endmodule
